// File: src/tfn_pkg.sv
// shared types and widths for the triangle face normal block
package tfn_pkg;

  localparam int CoordW = 16;
  localparam int EdgeW  = 17;
  localparam int ProdW  = 34;
  localparam int CrossW = 34;
  localparam int MagW   = 33;
  localparam int SqW    = 66;
  localparam int SumW   = 68;
  localparam int RemW   = 104;
  localparam int QW     = 15;
  localparam int OutW   = 16;
  localparam int QBits  = 15;
  localparam int FracSh = 30;

  typedef struct packed {
    logic                      valid;
    logic                      last;
    logic                      deg;
    logic [SumW-1:0]           s;
    logic [2:0][RemW-1:0]      r;
    logic [2:0][RemW-1:0]      p;
    logic [2:0][QW-1:0]        q;
    logic [2:0]                neg;
  } tfn_cell_t;

endpackage

// File: src/tfn_front.sv
// edge, cross product, square and sum stages ahead of the cell row
module tfn_front import tfn_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     valid_in,
  input  logic                     last_in,
  input  logic [2:0][CoordW-1:0]   a,
  input  logic [2:0][CoordW-1:0]   b,
  input  logic [2:0][CoordW-1:0]   c,
  output tfn_cell_t                cell_out
);

  logic [3:0] v_r;
  logic [3:0] l_r;
  logic signed [EdgeW-1:0]  e1_r [3];
  logic signed [EdgeW-1:0]  e2_r [3];
  logic signed [ProdW-1:0]  pa_r [3];
  logic signed [ProdW-1:0]  pb_r [3];
  logic signed [CrossW-1:0] n_r  [3];
  logic [SqW-1:0]           sq_r [3];
  logic [2:0]               ng_r;
  tfn_cell_t                co_r;
  logic [SumW-1:0]          s_sum;

  assign s_sum = SumW'(sq_r[0]) + SumW'(sq_r[1]) + SumW'(sq_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
      co_r.valid <= 1'b0;
    end else if (en) begin
      v_r <= {v_r[2:0], valid_in};
      co_r.valid <= v_r[3];
    end
    if (en) begin
      l_r <= {l_r[2:0], last_in};
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= EdgeW'($signed(b[i])) - EdgeW'($signed(a[i]));
        e2_r[i] <= EdgeW'($signed(c[i])) - EdgeW'($signed(a[i]));
      end
      // cross terms: n_i = e1[j]*e2[k] - e1[k]*e2[j]
      for (int i = 0; i < 3; i++) begin
        pa_r[i] <= ProdW'(e1_r[(i+1)%3] * e2_r[(i+2)%3]);
        pb_r[i] <= ProdW'(e1_r[(i+2)%3] * e2_r[(i+1)%3]);
        n_r[i]  <= pa_r[i] - pb_r[i];
      end
      for (int i = 0; i < 3; i++) begin
        logic [MagW-1:0] m;
        m = n_r[i][CrossW-1] ? MagW'(-n_r[i]) : MagW'(n_r[i]);
        sq_r[i] <= SqW'(m * m);
        ng_r[i] <= n_r[i][CrossW-1];
      end
      co_r.last <= l_r[3];
      co_r.deg  <= (s_sum == '0);
      co_r.s    <= s_sum;
      co_r.neg  <= ng_r;
      co_r.q    <= '0;
      for (int i = 0; i < 3; i++) begin
        // remainder starts at t - s for odd = -1, product register at -s
        co_r.r[i] <= (RemW'(sq_r[i]) << FracSh) - RemW'(s_sum);
        co_r.p[i] <= -RemW'(s_sum);
      end
    end
  end

  assign cell_out = co_r;

endmodule

// File: src/tfn_cell.sv
// one quotient bit of all three components, restoring step on shifted terms
module tfn_cell import tfn_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  tfn_cell_t cell_in,
  output tfn_cell_t cell_out
);

  tfn_cell_t cell_nxt;
  tfn_cell_t cell_r;

  always_comb begin
    logic signed [RemW-1:0] sub;
    logic signed [RemW-1:0] diff;
    cell_nxt = cell_in;
    for (int i = 0; i < 3; i++) begin
      sub  = ($signed(cell_in.p[i]) <<< (BIT + 2))
           + ($signed(RemW'(cell_in.s)) <<< (2 * BIT + 2));
      diff = $signed(cell_in.r[i]) - sub;
      if (!diff[RemW-1]) begin
        cell_nxt.r[i] = diff;
        cell_nxt.p[i] = cell_in.p[i] + (RemW'(cell_in.s) << (BIT + 1));
        cell_nxt.q[i] = cell_in.q[i] | (QW'(1) << BIT);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_out = cell_r;

endmodule

// File: src/triangle_face_normal.sv
// Triangle face normal: fully pipelined, one triangle accepted per cycle unless
// stalled, and one result per triangle (5 front stages for edges, cross product,
// squares and sum, then a row of 15 cells each settling one rounded quotient bit,
// then the output register). The whole pipeline holds while a result waits
// unaccepted; a degenerate triangle gives a zero normal with degenerate set.
module triangle_face_normal import tfn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CoordW-1:0] in_ax,
  input  logic [CoordW-1:0] in_ay,
  input  logic [CoordW-1:0] in_az,
  input  logic [CoordW-1:0] in_bx,
  input  logic [CoordW-1:0] in_by,
  input  logic [CoordW-1:0] in_bz,
  input  logic [CoordW-1:0] in_cx,
  input  logic [CoordW-1:0] in_cy,
  input  logic [CoordW-1:0] in_cz,
  input  logic              in_last_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [OutW-1:0]   out_normal_x,
  output logic [OutW-1:0]   out_normal_y,
  output logic [OutW-1:0]   out_normal_z,
  output logic              out_degenerate,
  output logic              out_last_out
);

  logic      en;
  tfn_cell_t chain [QBits+1];
  logic      ov_r;
  logic [2:0][OutW-1:0] nrm_r;
  logic      deg_r;
  logic      last_r;

  assign en       = !ov_r || out_ready;
  assign in_ready = en;

  tfn_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .valid_in (in_valid && en),
    .last_in  (in_last_in),
    .a        ({in_az, in_ay, in_ax}),
    .b        ({in_bz, in_by, in_bx}),
    .c        ({in_cz, in_cy, in_cx}),
    .cell_out (chain[0])
  );

  for (genvar k = 0; k < QBits; k++) begin : g_cell
    tfn_cell #(.BIT(QBits - 1 - k)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .cell_in  (chain[k]),
      .cell_out (chain[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= chain[QBits].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      deg_r  <= chain[QBits].deg;
      last_r <= chain[QBits].last;
      for (int i = 0; i < 3; i++) begin
        if (chain[QBits].deg) begin
          nrm_r[i] <= '0;
        end else if (chain[QBits].neg[i]) begin
          nrm_r[i] <= -OutW'(chain[QBits].q[i]);
        end else begin
          nrm_r[i] <= OutW'(chain[QBits].q[i]);
        end
      end
    end
  end

  assign out_valid      = ov_r;
  assign out_normal_x   = nrm_r[0];
  assign out_normal_y   = nrm_r[1];
  assign out_normal_z   = nrm_r[2];
  assign out_degenerate = deg_r;
  assign out_last_out   = last_r;

`ifndef SYNTHESIS
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_normal_x == '0 && out_normal_y == '0 && out_normal_z == '0)
    else $error("degenerate result with nonzero normal");

  a_nondeg_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_degenerate |->
      out_normal_x != '0 || out_normal_y != '0 || out_normal_z != '0)
    else $error("nondegenerate result with zero normal");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $signed(out_normal_x) <= 16384 && $signed(out_normal_x) >= -16384)
    else $error("normal x out of unit range");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(nrm_r))
    else $error("pending result lost while stalled");
`endif

endmodule
